// ----- rtl/kpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_pkg: shared types and constants of the k-mer profile distance block
// Field widths, opcodes and the command and status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package kpd_pkg;

	// field widths of the request and response transactions
	localparam int SLOT_FIELD_W = 3;
	localparam int BASE_W       = 2;
	localparam int KLEN_W       = 3;
	localparam int DIST_W       = 48;
	localparam int COUNT_W      = 15;
	localparam int SQ_W         = 2 * COUNT_W;

	// opcodes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_DIST = 1'b1;

	// saturation limits and register reset value
	localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
	localparam logic [DIST_W-1:0]  DIST_MAX   = {DIST_W{1'b1}};
	localparam logic [KLEN_W-1:0]  KLEN_RESET = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch the request fields, clear the accumulator
		logic clr_all;   // clearing pass over the whole count memory
		logic clr_slot;  // clearing pass over one slot's table
		logic push_rd;   // update the window and read the k-mer count
		logic push_wr;   // write back the raised count
		logic dst_rd;    // read both slots at the sweep index
		logic out_load;  // move the sum into the response register
	} kpd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_op;      // opcode of the offered request
		logic in_first;   // first flag of the offered request
		logic init_last;  // sweep at the last memory address
		logic row_last;   // sweep at the last k-mer of a table
		logic pipe_busy;  // distance pipeline still holds data
		logic out_busy;   // response register holds an untaken result
	} kpd_status_t;

endpackage

// ----- rtl/kpd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_if: request and response channels
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface kpd_req_if import kpd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    opcode;
	logic [SLOT_FIELD_W-1:0] slot_a;
	logic [SLOT_FIELD_W-1:0] slot_b;
	logic [BASE_W-1:0]       base_code;
	logic                    first_symbol;

	modport source (output valid, opcode, slot_a, slot_b, base_code, first_symbol,
		input ready);
	modport sink (input valid, opcode, slot_a, slot_b, base_code, first_symbol,
		output ready);
endinterface

interface kpd_rsp_if import kpd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;

	modport source (output valid, distance, input ready);
	modport sink (input valid, distance, output ready);
endinterface

// ----- rtl/kpd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_ctrl: sequencing state machine
// Runs the clearing pass after reset, the read-modify-write of a symbol
// transaction and the table sweep of a distance transaction.
// ----------------------------------------------------------------------------
module kpd_ctrl import kpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  kpd_status_t status,
	output kpd_cmd_t    cmd
);

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_CLR  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_DST  = 3'd5;
	localparam logic [2:0] S_DRN  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.clr_all = 1'b1;
				if (status.init_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.in_op == OP_DIST) state_nx = S_DST;
					else if (status.in_first) state_nx = S_CLR;
					else state_nx = S_RD;
				end
			end
			S_CLR: begin
				cmd.clr_slot = 1'b1;
				if (status.row_last) state_nx = S_RD;
			end
			S_RD: begin
				cmd.push_rd = 1'b1;
				state_nx    = S_WR;
			end
			S_WR: begin
				cmd.push_wr = 1'b1;
				state_nx    = S_IDLE;
			end
			S_DST: begin
				cmd.dst_rd = 1'b1;
				if (status.row_last) state_nx = S_DRN;
			end
			S_DRN: begin
				if (!status.pipe_busy && !status.out_busy) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_INIT;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_nx;
	end

endmodule

// ----- rtl/kpd_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_dp: count memory, windows and distance pipeline
// Holds the per-slot symbol windows, the count memory with one write and two
// read ports, and the difference, square and saturating sum stages.
// ----------------------------------------------------------------------------
module kpd_dp import kpd_pkg::*; #(
	parameter int K_MAX     = 6,
	parameter int NUM_SLOTS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  kpd_cmd_t                cmd,
	output kpd_status_t             status,
	input  logic [KLEN_W-1:0]       kmer_length,
	input  logic                    in_opcode,
	input  logic [SLOT_FIELD_W-1:0] in_slot_a,
	input  logic [SLOT_FIELD_W-1:0] in_slot_b,
	input  logic [BASE_W-1:0]       in_base,
	input  logic                    in_first,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [DIST_W-1:0]       out_distance
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int WIN_W  = 2 * K_MAX;
	localparam int FILL_W = $clog2(K_MAX + 1);
	localparam int ADDR_W = SLOT_W + WIN_W;
	localparam int DEPTH  = NUM_SLOTS * (1 << WIN_W);

	// slot field folded into the slot range
	function automatic logic [SLOT_W-1:0] slot_fold(input logic [SLOT_FIELD_W-1:0] s);
		logic [6:0] v;
		v = {4'd0, s};
		for (int i = 0; i < 4; i++) begin
			if (v >= 7'(NUM_SLOTS)) v = v - 7'(NUM_SLOTS);
		end
		return SLOT_W'(v);
	endfunction

	logic [SLOT_W-1:0]  slot_a_q;
	logic [SLOT_W-1:0]  slot_b_q;
	logic [BASE_W-1:0]  base_q;
	logic               first_q;
	logic [WIN_W-1:0]   win_q [NUM_SLOTS];
	logic [FILL_W-1:0]  fill_q [NUM_SLOTS];
	logic [WIN_W-1:0]   kidx_q;
	logic               hit_q;
	logic [ADDR_W-1:0]  sweep_q;
	logic [COUNT_W-1:0] cnt_mem_q [DEPTH];
	logic [COUNT_W-1:0] rd_a_s1;
	logic [COUNT_W-1:0] rd_b_s1;
	logic               vld_s1;
	logic [COUNT_W-1:0] absd_s2;
	logic               vld_s2;
	logic [SQ_W-1:0]    sq_s3;
	logic               vld_s3;
	logic [DIST_W-1:0]  acc_q;
	logic [DIST_W-1:0]  dist_q;
	logic               out_vld_q;

	logic [FILL_W-1:0]  k_eff;
	logic [WIN_W-1:0]   kmask;
	logic [WIN_W-1:0]   cur_win;
	logic [FILL_W-1:0]  cur_fill;
	logic [WIN_W-1:0]   new_win;
	logic [FILL_W-1:0]  new_fill;
	logic [WIN_W-1:0]   new_kidx;
	logic               new_hit;
	logic               init_last;
	logic               row_last;
	logic [ADDR_W-1:0]  wr_addr;
	logic [COUNT_W-1:0] wr_data;
	logic               wr_en;
	logic [ADDR_W-1:0]  rd_addr_a;
	logic [ADDR_W-1:0]  rd_addr_b;
	logic [DIST_W:0]    acc_sum;

	// effective k and the k-mer mask
	always_comb begin
		logic [3:0] kl;
		kl = {1'b0, kmer_length};
		if (kl == 4'd0) kl = 4'd1;
		if (kl > 4'(K_MAX)) kl = 4'(K_MAX);
		k_eff = FILL_W'(kl);
		for (int j = 0; j < WIN_W; j++) begin
			kmask[j] = ((j >> 1) < int'(k_eff));
		end
	end

	// window shift for the latched symbol
	always_comb begin
		cur_win  = first_q ? '0 : win_q[slot_a_q];
		cur_fill = first_q ? '0 : fill_q[slot_a_q];
		new_win  = WIN_W'({cur_win, base_q});
		new_fill = (cur_fill < FILL_W'(K_MAX)) ? cur_fill + FILL_W'(1) : cur_fill;
		new_hit  = (new_fill >= k_eff);
		new_kidx = new_win & kmask;
	end

	// sweep position
	assign init_last = (sweep_q == ADDR_W'(DEPTH - 1));
	assign row_last  = &sweep_q[WIN_W-1:0];

	// memory port addressing
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sweep_q;
		wr_data = '0;
		if (cmd.clr_all) begin
			wr_en = 1'b1;
		end else if (cmd.clr_slot) begin
			wr_en   = 1'b1;
			wr_addr = {slot_a_q, sweep_q[WIN_W-1:0]};
		end else if (cmd.push_wr && hit_q) begin
			wr_en   = 1'b1;
			wr_addr = {slot_a_q, kidx_q};
			wr_data = (rd_a_s1 == COUNT_MAX) ? rd_a_s1 : rd_a_s1 + COUNT_W'(1);
		end
		rd_addr_a = cmd.push_rd ? {slot_a_q, new_kidx} : {slot_a_q, sweep_q[WIN_W-1:0]};
		rd_addr_b = {slot_b_q, sweep_q[WIN_W-1:0]};
	end

	// count memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) cnt_mem_q[wr_addr] <= wr_data;
		rd_a_s1 <= cnt_mem_q[rd_addr_a];
		rd_b_s1 <= cnt_mem_q[rd_addr_b];
	end

	// latched request fields and k-mer address
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_a_q <= slot_fold(in_slot_a);
			slot_b_q <= slot_fold(in_slot_b);
			base_q   <= in_base;
			first_q  <= in_first;
		end
		if (cmd.push_rd) kidx_q <= new_kidx;
	end

	// windows, fill counts, sweep counter and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				win_q[s]  <= '0;
				fill_q[s] <= '0;
			end
			sweep_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (cmd.push_rd) begin
				win_q[slot_a_q]  <= new_win;
				fill_q[slot_a_q] <= new_fill;
				hit_q            <= new_hit;
			end
			if (cmd.clr_all) begin
				sweep_q <= init_last ? '0 : sweep_q + ADDR_W'(1);
			end else if (cmd.clr_slot || cmd.dst_rd) begin
				sweep_q <= row_last ? '0 : sweep_q + ADDR_W'(1);
			end
		end
	end

	// difference and square stages
	always_ff @(posedge clk) begin
		absd_s2 <= (rd_a_s1 >= rd_b_s1) ? rd_a_s1 - rd_b_s1 : rd_b_s1 - rd_a_s1;
		sq_s3   <= SQ_W'(absd_s2) * SQ_W'(absd_s2);
	end

	// saturating sum
	assign acc_sum = {1'b0, acc_q} + (DIST_W + 1)'(sq_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			acc_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.dst_rd;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (cmd.load) acc_q <= '0;
			else if (vld_s3) acc_q <= acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];
			if (cmd.out_load) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.out_load) dist_q <= acc_q;
	end

	assign out_valid    = out_vld_q;
	assign out_distance = dist_q;

	// status back to the controller
	always_comb begin
		status.in_op     = in_opcode;
		status.in_first  = in_first;
		status.init_last = init_last;
		status.row_last  = row_last;
		status.pipe_busy = vld_s1 | vld_s2 | vld_s3;
		status.out_busy  = out_vld_q & ~out_ready;
	end

endmodule

// ----- rtl/kmer_profile_distance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_profile_distance: k-mer count profiles and their distance
// Counts k-mers of symbol streams per slot and returns the saturating sum
// of squared count differences between two slots.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the count memory of
// NUM_SLOTS * 4^K_MAX entries and accepts no request until it ends;
// kmer_length writes are taken throughout. A symbol transaction steps
// through accept, count read and count write, since every symbol is a
// read-modify-write through the single write port of the count memory;
// with first_symbol set, a clearing pass over the slot's table comes first.
// A distance transaction sweeps both tables through the two read ports, one
// k-mer a cycle, and its result is loaded into the response register once
// the pipeline drains and the previous result has been taken. Symbol
// transactions are accepted while a result waits in the response register.
module kmer_profile_distance import kpd_pkg::*; #(
	parameter int K_MAX     = 6,
	parameter int NUM_SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [KLEN_W-1:0] cfg_wdata,
	kpd_req_if.sink           req,
	kpd_rsp_if.source         resp
);

	logic [KLEN_W-1:0] kmer_length_q;
	kpd_cmd_t          cmd;
	kpd_status_t       status;
	logic              in_ready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) kmer_length_q <= KLEN_RESET;
		else if (cfg_we) kmer_length_q <= cfg_wdata;
	end

	// controller
	kpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign req.ready = in_ready;

	// datapath
	kpd_dp #(
		.K_MAX     (K_MAX),
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.kmer_length  (kmer_length_q),
		.in_opcode    (req.opcode),
		.in_slot_a    (req.slot_a),
		.in_slot_b    (req.slot_b),
		.in_base      (req.base_code),
		.in_first     (req.first_symbol),
		.out_ready    (resp.ready),
		.out_valid    (resp.valid),
		.out_distance (resp.distance)
	);

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(resp.valid && !resp.ready))
		else $error("result loaded over an untaken result");

	// memory sequencing commands are mutually exclusive
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_all, cmd.clr_slot, cmd.push_rd, cmd.push_wr, cmd.dst_rd}))
		else $error("conflicting memory commands");

	// no request is accepted while the table is being walked or written
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |->
		!(cmd.clr_all || cmd.clr_slot || cmd.push_wr || cmd.dst_rd || status.pipe_busy))
		else $error("request accepted during table activity");

	// a symbol transaction reads its count in the cycle after acceptance unless cleared
	a_push_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.opcode == OP_PUSH && !req.first_symbol)
		|=> cmd.push_rd)
		else $error("symbol transaction did not start its count read");

endmodule

// ----- sim/kpd_distance_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_distance_checker: scoreboard for the k-mer profile distance block
// Watches the request, response and kmer_length channels, keeps its own
// per-slot k-mer count profiles and predicts each distance. Every returned
// distance is compared with the oldest prediction in order.
// ----------------------------------------------------------------------------
module kpd_distance_checker import kpd_pkg::*; #(
	parameter int K_MAX     = 6,
	parameter int NUM_SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [KLEN_W-1:0] cfg_wdata,
	kpd_req_if                req,
	kpd_rsp_if                resp,
	output int unsigned       mismatches,
	output int unsigned       outstanding
);

	localparam int KMER_SPACE = 1 << (2 * K_MAX);
	localparam int WIN_W      = 2 * K_MAX;

	typedef logic [COUNT_W-1:0] count_t;

	// predicted state of every slot
	count_t             profile [NUM_SLOTS * KMER_SPACE];
	logic [WIN_W-1:0]   window [NUM_SLOTS];
	int unsigned        window_fill [NUM_SLOTS];
	logic [KLEN_W-1:0]  kmer_length;
	logic [DIST_W-1:0]  expected_distances [$];
	logic [DIST_W-1:0]  want;

	task automatic report_mismatch(input string what);
		$display("[%0t] ERROR %s", $time, what);
		mismatches++;
	endtask

	// k as the block uses it: zero acts as one, large values clip to K_MAX
	function automatic int unsigned active_k();
		if (kmer_length == 0)
			return 1;
		if (kmer_length > K_MAX)
			return K_MAX;
		return kmer_length;
	endfunction

	// shift one symbol into a slot and raise the count of the completed k-mer
	task automatic count_symbol(input int unsigned slot, input logic [BASE_W-1:0] base,
		input logic first);
		int unsigned      k;
		int unsigned      row;
		int unsigned      i;
		logic [WIN_W-1:0] kmer;
		k   = active_k();
		row = slot * KMER_SPACE;
		if (first) begin
			for (i = 0; i < KMER_SPACE; i++)
				profile[row + i] = '0;
			window[slot]      = '0;
			window_fill[slot] = 0;
		end
		window[slot] = (window[slot] << BASE_W) | {{(WIN_W - BASE_W){1'b0}}, base};
		if (window_fill[slot] < K_MAX)
			window_fill[slot]++;
		// short sequence: no k-mer until k symbols are held
		if (window_fill[slot] >= k) begin
			kmer = window[slot] & WIN_W'((1 << (2 * k)) - 1);
			if (profile[row + kmer] != COUNT_MAX)
				profile[row + kmer] = profile[row + kmer] + 1'b1;
		end
	endtask

	// saturating sum of squared count differences over the whole table
	function automatic logic [DIST_W-1:0] profile_distance(input int unsigned a,
		input int unsigned b);
		logic [63:0] sum;
		logic [63:0] d;
		count_t      ca;
		count_t      cb;
		int unsigned i;
		sum = '0;
		for (i = 0; i < KMER_SPACE; i++) begin
			ca = profile[a * KMER_SPACE + i];
			cb = profile[b * KMER_SPACE + i];
			d  = (ca >= cb) ? 64'(ca - cb) : 64'(cb - ca);
			sum = sum + d * d;
			if (sum > 64'(DIST_MAX))
				sum = 64'(DIST_MAX);
		end
		return sum[DIST_W-1:0];
	endfunction

	// follow every transaction and register write
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (profile[i])
				profile[i] = '0;
			foreach (window[i]) begin
				window[i]      = '0;
				window_fill[i] = 0;
			end
			kmer_length = KLEN_RESET;
			expected_distances.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_we)
				kmer_length = cfg_wdata;
			if (req.valid && req.ready) begin
				if (req.opcode == OP_PUSH)
					count_symbol(req.slot_a % NUM_SLOTS, req.base_code, req.first_symbol);
				else
					expected_distances.insert(expected_distances.size(),
						profile_distance(req.slot_a % NUM_SLOTS, req.slot_b % NUM_SLOTS));
			end
			if (resp.valid && resp.ready) begin
				if (expected_distances.size() == 0) begin
					report_mismatch($sformatf("distance %0d returned with no query waiting",
						resp.distance));
				end else begin
					want = expected_distances.pop_front();
					if (resp.distance !== want)
						report_mismatch($sformatf("distance got %0d, want %0d",
							resp.distance, want));
				end
			end
			outstanding = expected_distances.size();
		end
	end

endmodule

// ----- sim/kmer_profile_distance_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_profile_distance_test: testbench top of the k-mer profile distance block
// Drives symbol and distance transactions with random idling on both sides,
// walks kmer_length through all its codes, repeats one k-mer into a slot,
// stalls the response side for a long stretch, and gives the verdict of the
// checker.
// ----------------------------------------------------------------------------
module kmer_profile_distance_test;
	import kpd_pkg::*;

	localparam int K_MAX          = 6;
	localparam int NUM_SLOTS      = 8;
	localparam int TABLE_CYCLES   = (1 << (2 * K_MAX)) + 5;
	localparam int SETTLE_CYCLES  = TABLE_CYCLES + 64;
	localparam int HOLD_CYCLES    = 3 * TABLE_CYCLES + 500;
	localparam int WATCHDOG_LIMIT = 4 * (NUM_SLOTS << (2 * K_MAX)) + 4 * HOLD_CYCLES;
	localparam int RANDOM_ITEMS   = 85;
	localparam int REPEAT_ITEMS   = 24;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [KLEN_W-1:0] cfg_wdata;
	int unsigned       mismatch_count;
	int unsigned       pending_results;
	int unsigned       idle_max;
	int unsigned       hold_requests;
	int unsigned       holds_done;

	kpd_req_if req_ch ();
	kpd_rsp_if rsp_ch ();

	kmer_profile_distance #(
		.K_MAX(K_MAX),
		.NUM_SLOTS(NUM_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.resp(rsp_ch)
	);

	kpd_distance_checker #(
		.K_MAX(K_MAX),
		.NUM_SLOTS(NUM_SLOTS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.resp(rsp_ch),
		.mismatches(mismatch_count),
		.outstanding(pending_results)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one request transaction after a random gap; called at a falling edge
	task automatic send_request(input logic op, input logic [SLOT_FIELD_W-1:0] a,
		input logic [SLOT_FIELD_W-1:0] b, input logic [BASE_W-1:0] base, input logic first);
		int unsigned gap;
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.opcode       <= op;
		req_ch.slot_a       <= a;
		req_ch.slot_b       <= b;
		req_ch.base_code    <= base;
		req_ch.first_symbol <= first;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// symbol transaction, the unused slot field random
	task automatic push_symbol(input logic [SLOT_FIELD_W-1:0] slot,
		input logic [BASE_W-1:0] base, input logic first);
		send_request(OP_PUSH, slot, SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1)), base,
			first);
	endtask

	// distance transaction, the unused symbol fields random
	task automatic query(input logic [SLOT_FIELD_W-1:0] a, input logic [SLOT_FIELD_W-1:0] b);
		send_request(OP_DIST, a, b, BASE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
	endtask

	// stop offering, wait for every result, then let a slot clear finish
	task automatic wait_for_quiet();
		req_ch.valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_kmer_length(input logic [KLEN_W-1:0] value);
		wait_for_quiet();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly runs of symbols into one slot, with occasional restarts and queries
	task automatic run_random_items(input int unsigned count);
		logic [SLOT_FIELD_W-1:0] cur_slot;
		logic [SLOT_FIELD_W-1:0] qa;
		int unsigned             i;
		cur_slot = SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1));
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 8) begin
				qa = SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1));
				if ($urandom_range(0, 7) == 0)
					query(qa, qa);
				else
					query(qa, SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1)));
			end else begin
				if ($urandom_range(0, 7) == 0)
					cur_slot = SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1));
				push_symbol(cur_slot, BASE_W'($urandom_range(0, 3)),
					$urandom_range(0, 39) == 0);
			end
		end
	endtask

	// response side: random stalls per transaction, plus long hold-offs on request
	initial begin
		int unsigned stall;
		rsp_ch.ready = 1'b0;
		holds_done   = 0;
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, idle_max);
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				stall += HOLD_CYCLES;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid && holds_done == hold_requests);
			@(negedge clk);
		end
	end

	// watchdog on cycles with no transaction on either channel
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	// stimulus and verdict
	initial begin
		logic [KLEN_W-1:0] k_plan [8] = '{3'd0, 3'd6, 3'd2, 3'd7, 3'd3, 3'd5, 3'd1, 3'd4};
		int unsigned       phase;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.opcode       = OP_PUSH;
		req_ch.slot_a       = '0;
		req_ch.slot_b       = '0;
		req_ch.base_code    = '0;
		req_ch.first_symbol = 1'b0;
		idle_max            = 14;
		hold_requests       = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: short sequences, same slot, restart and shared k-mers at k = 4
		set_kmer_length(3'd4);
		push_symbol(3'd0, 2'd3, 1'b1);
		push_symbol(3'd0, 2'd0, 1'b0);
		push_symbol(3'd0, 2'd2, 1'b0);
		query(3'd0, 3'd1);
		query(3'd7, 3'd7);
		push_symbol(3'd0, 2'd1, 1'b0);
		query(3'd0, 3'd1);
		push_symbol(3'd7, 2'd3, 1'b1);
		push_symbol(3'd7, 2'd0, 1'b0);
		push_symbol(3'd7, 2'd2, 1'b0);
		push_symbol(3'd7, 2'd1, 1'b0);
		query(3'd0, 3'd7);
		push_symbol(3'd7, 2'd3, 1'b0);
		query(3'd7, 3'd0);
		push_symbol(3'd0, 2'd1, 1'b1);
		query(3'd0, 3'd7);

		// one k-mer repeated into a single slot at k = 1, no idling
		set_kmer_length(3'd1);
		idle_max = 0;
		push_symbol(3'd5, 2'd2, 1'b1);
		repeat (REPEAT_ITEMS) push_symbol(3'd5, 2'd2, 1'b0);
		idle_max = 14;
		query(3'd5, 3'd6);
		query(3'd5, 3'd5);

		// response side holds off while queries pile up behind each other
		set_kmer_length(3'd7);
		hold_requests++;
		idle_max = 0;
		query(3'd0, 3'd7);
		query(3'd5, 3'd0);
		push_symbol(3'd7, 2'd2, 1'b0);
		query(3'd7, 3'd5);
		query(3'd1, 3'd7);
		idle_max = 14;

		// random phases through every kmer_length code; sequences carry across
		for (phase = 0; phase < 8; phase++) begin
			set_kmer_length(k_plan[phase]);
			idle_max = (phase % 3 == 2) ? 0 : 14;
			run_random_items(RANDOM_ITEMS);
		end
		idle_max = 14;

		wait_for_quiet();
		if (mismatch_count == 0 && pending_results == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
